>>> hdl/btt_pkg.sv
// ----------------------------------------------------------------------------
// btt_pkg: shared types and constants of the blob track table
// codes for input kinds, statuses, life states and register indexes
// ----------------------------------------------------------------------------
package btt_pkg;

  localparam int TableDepthDef = 16;

  localparam int XW = 14;
  localparam int YW = 13;
  localparam int IdW = 16;
  localparam int StampW = 32;

  localparam logic KIND_DET = 1'b0;
  localparam logic KIND_EOB = 1'b1;

  localparam logic [1:0] ST_MATCHED = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic [1:0] LIFE_UPCOMING = 2'd0;
  localparam logic [1:0] LIFE_ALIVE    = 2'd1;
  localparam logic [1:0] LIFE_DYING    = 2'd2;

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_GAIN   = 3'd1;
  localparam logic [2:0] REG_MINSTP = 3'd2;
  localparam logic [2:0] REG_MAXSTP = 3'd3;
  localparam logic [2:0] REG_EXPIRE = 3'd4;
  localparam logic [2:0] REG_DYING  = 3'd5;
  localparam logic [2:0] REG_ALIVE  = 3'd6;

  typedef struct packed {
    logic [7:0] match_radius;
    logic [8:0] smoothing_gain;
    logic [7:0] min_step;
    logic [7:0] max_step;
    logic [7:0] expire_after;
    logic [7:0] dying_after;
    logic [7:0] alive_after;
  } cfg_t;

  // one slot as stored in the table
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [XW-1:0]     x;
    logic [YW-1:0]     y;
    logic [XW-1:0]     px;
    logic [YW-1:0]     py;
    logic [StampW-1:0] stamp;
    logic [7:0]        age;
    logic [1:0]        life;
    logic [7:0]        alpha;
  } slot_t;

  localparam int SlotW = $bits(slot_t);

  // result record handed to the output register
  typedef struct packed {
    logic        report_kind;
    logic [1:0]  status;
    logic [IdW-1:0] track_id;
    logic [XW-1:0] pos_x;
    logic [YW-1:0] pos_y;
    logic [XW-1:0] prev_x;
    logic [YW-1:0] prev_y;
    logic [1:0]  life_state;
    logic [7:0]  alpha;
    logic        last;
  } res_t;

endpackage

>>> hdl/blob_track_table_unit.sv
// ----------------------------------------------------------------------------
// blob_track_table_unit: nearest neighbor blob tracker with a slot table
// detection matching, track opening and end-of-batch aging and reporting
// ----------------------------------------------------------------------------
// channels: s_axis carries one request; tuser is kind (0 detection, 1 end of
// batch), tdata holds det_x, det_y and frame_num. m_axis carries results;
// tuser holds report_kind, tlast marks the final result of a request.
// cfg_* writes one register (index as in the register list); the user must
// write only while idle, as the block does not enforce it. a detection walks
// every slot through the shared slot unit, a read state and a write-back state
// per slot, then gives its result; an end of batch adds a report pass of one
// slot per cycle while the receiver does not stall.
// the table is a register file read a slot at a time; the slot unit sets the pace.
// one request is handled at a time; s_axis_tready is low while busy.
// reset clears the valid bits, the id counter, the registers to defaults and
// the output register; slot contents stay undefined until written.
// on a receiver stall the result waits in the output register, the sequencer holds.
// ----------------------------------------------------------------------------
module blob_track_table_unit #(
  parameter int TABLE_DEPTH = btt_pkg::TableDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // det_x[9:0], det_y[18:10], frame_num[50:19]
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], track_id[17:2], pos_x[31:18], pos_y[44:32],
  // prev_x[58:45], prev_y[71:59], life_state[73:72], alpha[81:74]
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tuser,  // report_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int SW = $clog2(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;   // slot unit working on current slot
  localparam logic [2:0] S_WB   = 3'd2;   // write back result of slot
  localparam logic [2:0] S_FIN  = 3'd3;   // detection result / new track
  localparam logic [2:0] S_REP  = 3'd4;   // report sweep
  localparam logic [2:0] S_OUT  = 3'd5;   // wait for output register

  logic [2:0] state;
  btt_pkg::cfg_t cfg;
  logic [TABLE_DEPTH-1:0] valid;
  btt_pkg::slot_t tab [TABLE_DEPTH];
  logic [15:0] next_id;

  logic        kind;
  logic [13:0] tx;
  logic [12:0] ty;
  logic [31:0] frame;
  logic [SW-1:0] idx;
  logic          idx_end;
  logic          found, freefound;
  logic [SW-1:0] first, freeslot;
  logic          any_rep;

  logic hit, stale;
  btt_pkg::slot_t det_out, eob_out;

  btt_pkg::res_t res;
  logic          res_valid;
  logic          res_load;

  btt_slot_unit u_slot (
    .clk(clk), .cfg(cfg), .slot_in(tab[idx]), .tx(tx), .ty(ty), .frame(frame),
    .hit(hit), .stale(stale), .det_out(det_out), .eob_out(eob_out)
  );

  assign s_axis_tready = (state == S_IDLE) && !res_valid;
  assign cfg_ready = 1'b1;
  assign idx_end = (idx == SW'(TABLE_DEPTH - 1));
  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser = res.report_kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {6'b0, res.alpha, res.life_state, res.prev_y, res.prev_x,
                         res.pos_y, res.pos_x, res.track_id, res.status};

  // output register takes a new result this cycle
  always_comb begin
    if (state == S_FIN)
      res_load = !res_valid;
    else if (state == S_REP)
      res_load = (!res_valid || m_axis_tready) && (valid[idx] || (idx_end && !any_rep));
    else
      res_load = 1'b0;
  end

  // later valid slot exists beyond idx (for tlast of reports)
  function automatic logic more_after(input logic [TABLE_DEPTH-1:0] v, input logic [SW-1:0] i);
    logic m;
    begin
      m = 1'b0;
      for (int k = 0; k < TABLE_DEPTH; k++)
        if (k > int'(i) && v[k]) m = 1'b1;
      more_after = m;
    end
  endfunction

  function automatic btt_pkg::res_t mk(input logic rk, input logic [1:0] st,
                                       input btt_pkg::slot_t s, input logic use_s,
                                       input logic lst);
    btt_pkg::res_t r;
    begin
      r = '0;
      r.report_kind = rk;
      r.status = st;
      r.last = lst;
      if (use_s) begin
        r.track_id = s.id; r.pos_x = s.x; r.pos_y = s.y;
        r.prev_x = s.px; r.prev_y = s.py; r.life_state = s.life; r.alpha = s.alpha;
      end
      mk = r;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{8'd25, 9'd205, 8'd4, 8'd25, 8'd40, 8'd2, 8'd40};
      state <= S_IDLE;
      valid <= '0;
      next_id <= '0;
      res_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (res_valid && m_axis_tready && !res_load) res_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          btt_pkg::REG_RADIUS: cfg.match_radius <= cfg_data[7:0];
          btt_pkg::REG_GAIN:   cfg.smoothing_gain <= cfg_data;
          btt_pkg::REG_MINSTP: cfg.min_step <= cfg_data[7:0];
          btt_pkg::REG_MAXSTP: cfg.max_step <= cfg_data[7:0];
          btt_pkg::REG_EXPIRE: cfg.expire_after <= cfg_data[7:0];
          btt_pkg::REG_DYING:  cfg.dying_after <= cfg_data[7:0];
          btt_pkg::REG_ALIVE:  cfg.alive_after <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind <= s_axis_tuser;
            tx <= {s_axis_tdata[9:0], 4'b0};
            ty <= {s_axis_tdata[18:10], 4'b0};
            frame <= s_axis_tdata[50:19];
            idx <= '0;
            found <= 1'b0;
            freefound <= 1'b0;
            any_rep <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_WB;
        S_WB: begin
          if (kind == btt_pkg::KIND_DET) begin
            if (!valid[idx]) begin
              if (!freefound) begin
                freefound <= 1'b1;
                freeslot <= idx;
              end
            end else if (hit) begin
              tab[idx] <= det_out;
              if (!found) begin
                found <= 1'b1;
                first <= idx;
              end
            end
          end else if (valid[idx]) begin
            if (stale) valid[idx] <= 1'b0;
            else tab[idx] <= eob_out;
          end
          if (idx_end) begin
            state <= (kind == btt_pkg::KIND_DET) ? S_FIN : S_REP;
            idx <= (kind == btt_pkg::KIND_DET) ? idx : '0;
          end else begin
            idx <= idx + SW'(1);
            state <= S_READ;
          end
        end
        S_FIN: begin
          if (!res_valid) begin
            res_valid <= 1'b1;
            state <= S_OUT;
            if (found) begin
              res <= mk(1'b0, btt_pkg::ST_MATCHED, tab[first], 1'b1, 1'b1);
            end else if (freefound) begin
              valid[freeslot] <= 1'b1;
              tab[freeslot] <= '{next_id, tx, ty, tx, ty, frame, 8'd0,
                                 btt_pkg::LIFE_UPCOMING, 8'd0};
              res <= mk(1'b0, btt_pkg::ST_NEW,
                        btt_pkg::slot_t'{next_id, tx, ty, tx, ty, frame, 8'd0,
                                         btt_pkg::LIFE_UPCOMING, 8'd0}, 1'b1, 1'b1);
              next_id <= next_id + 16'd1;
            end else begin
              res <= mk(1'b0, btt_pkg::ST_DROPPED, tab[0], 1'b0, 1'b1);
            end
          end
        end
        S_REP: begin
          if (!res_valid || m_axis_tready) begin
            if (valid[idx]) begin
              res_valid <= 1'b1;
              res <= mk(1'b1, btt_pkg::ST_MATCHED, tab[idx], 1'b1,
                        !more_after(valid, idx));
              any_rep <= 1'b1;
            end
            if (idx_end) begin
              state <= S_OUT;
              if (!valid[idx] && !any_rep) begin
                res_valid <= 1'b1;
                res <= mk(1'b1, btt_pkg::ST_EMPTY, tab[0], 1'b0, 1'b1);
              end
            end else begin
              idx <= idx + SW'(1);
            end
          end
        end
        S_OUT: begin
          if (!res_valid || m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a request is never taken while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !res_valid) else $error("accept while result pending");
  // the id counter moves only when a track is opened
  a_id_step: assert property (@(posedge clk) disable iff (rst)
    (next_id != $past(next_id)) |-> ($past(state) == S_FIN))
    else $error("id counter moved outside track opening");
  // report sweep only follows an end of batch request
  a_rep_kind: assert property (@(posedge clk) disable iff (rst)
    (state == S_REP) |-> (kind == btt_pkg::KIND_EOB)) else $error("sweep on detection");

endmodule

>>> hdl/btt_slot_unit.sv
// ----------------------------------------------------------------------------
// btt_slot_unit: shared per-slot arithmetic
// one slot at a time: distance test and step for detections, aging for
// end of batch; registered result
// ----------------------------------------------------------------------------
module btt_slot_unit (
  input  logic                  clk,
  input  btt_pkg::cfg_t         cfg,
  input  btt_pkg::slot_t        slot_in,
  input  logic [btt_pkg::XW-1:0] tx,
  input  logic [btt_pkg::YW-1:0] ty,
  input  logic [31:0]           frame,
  output logic                  hit,
  output logic                  stale,
  output btt_pkg::slot_t        det_out,
  output btt_pkg::slot_t        eob_out
);

  logic signed [14:0] dx, dy;
  logic signed [29:0] sqx, sqy;
  logic [29:0] d2;
  logic [25:0] r2;
  logic [11:0] r16;
  logic [8:0] gain;
  logic [31:0] since;
  logic signed [11:0] a;
  btt_pkg::slot_t dn, en;

  function automatic logic [13:0] move(input logic [13:0] pos, input logic [13:0] tgt,
                                       input logic [8:0] g, input logic [7:0] mn,
                                       input logic [7:0] mx);
    logic [13:0] mag;
    logic [22:0] prod;
    logic [14:0] step;
    begin
      mag = (tgt >= pos) ? tgt - pos : pos - tgt;
      prod = mag * g;
      step = {1'b0, prod[21:8]};
      move = pos;
      if (step >= {3'b0, mn, 4'b0} && step <= {3'b0, mx, 4'b0})
        move = (tgt >= pos) ? pos + step[13:0] : pos - step[13:0];
    end
  endfunction

  always_comb begin
    gain = (cfg.smoothing_gain > 9'd256) ? 9'd256 : cfg.smoothing_gain;
    dx = $signed({1'b0, tx}) - $signed({1'b0, slot_in.x});
    dy = $signed({2'b0, ty}) - $signed({2'b0, slot_in.y});
    // full-width squares
    sqx = dx * dx;
    sqy = dy * dy;
    d2 = $unsigned(sqx) + $unsigned(sqy);
    r16 = {cfg.match_radius, 4'b0};
    r2 = r16 * r16;
    dn = slot_in;
    dn.px = slot_in.x;
    dn.py = slot_in.y;
    dn.x = move(slot_in.x, tx, gain, cfg.min_step, cfg.max_step);
    dn.y = 13'(move({1'b0, slot_in.y}, {1'b0, ty}, gain, cfg.min_step, cfg.max_step));
    dn.stamp = frame;

    since = frame - slot_in.stamp;
    en = slot_in;
    a = $signed({4'b0, slot_in.alpha});
    if (slot_in.life == btt_pkg::LIFE_UPCOMING)
      a = ($signed({4'b0, slot_in.age}) - 12'sd10) * 12'sd5;
    if (slot_in.age > cfg.alive_after) begin
      en.life = btt_pkg::LIFE_ALIVE;
      a = 12'sd255;
    end
    if (since > {24'b0, cfg.dying_after}) begin
      en.life = btt_pkg::LIFE_DYING;
      a = a - $signed({1'b0, since[7:0], 2'b0}) - $signed({4'b0, since[7:0]});
    end
    if (en.life != btt_pkg::LIFE_DYING && slot_in.age != 8'd255)
      en.age = slot_in.age + 8'd1;
    if (a > 12'sd255) en.alpha = 8'd255;
    else if (a < 12'sd0) en.alpha = 8'd0;
    else en.alpha = a[7:0];
  end

  always_ff @(posedge clk) begin
    hit <= {4'b0, d2} < {8'b0, r2} ? 1'b1 : 1'b0;
    stale <= since > {24'b0, cfg.expire_after};
    det_out <= dn;
    eob_out <= en;
  end

endmodule

>>> tb/sv/blob_track_table_unit_tb.sv
// ----------------------------------------------------------------------------
// blob_track_table_unit_tb: self-checking bench for the blob track table
// drives detections and end-of-batch requests over the stream port, keeps
// its own copy of the track table to predict every result, and compares the
// result stream field by field under random idling and receiver stalls
// ----------------------------------------------------------------------------
module blob_track_table_unit_tb;

  localparam int DEPTH = btt_pkg::TableDepthDef;
  localparam int LATENCY = 2 * DEPTH + 3 + DEPTH + 10;  // worst request plus margin
  localparam int IDLE_LIMIT = 3000;                     // cycles with no handshake
  localparam int HOLD_CYCLES = 300;                     // long receiver hold-off
  localparam logic [2:0] REG_UNMAPPED = 3'd7;           // index with no register

  // --------------------------------------------------------------------------
  // track table predictor and result store
  // --------------------------------------------------------------------------
  class track_scoreboard;
    bit          live [DEPTH];
    int unsigned id [DEPTH], px [DEPTH], py [DEPTH], ox [DEPTH], oy [DEPTH];
    int unsigned stamp [DEPTH], age [DEPTH], life [DEPTH], alpha [DEPTH];
    int unsigned next_id;
    int unsigned radius, gain, min_step, max_step, expire, dying, alive;
    btt_pkg::res_t expected_q [$];
    int          errors, n_req, n_res, n_new, n_drop, n_match, n_empty, n_tracks;

    function new();
      radius = 25; gain = 205; min_step = 4; max_step = 25;
      expire = 40; dying = 2; alive = 40;
      next_id = 0;
      foreach (live[j]) live[j] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [8:0] val);
      case (idx)
        btt_pkg::REG_RADIUS: radius = int'(val[7:0]);
        btt_pkg::REG_GAIN:   gain = int'(val);
        btt_pkg::REG_MINSTP: min_step = int'(val[7:0]);
        btt_pkg::REG_MAXSTP: max_step = int'(val[7:0]);
        btt_pkg::REG_EXPIRE: expire = int'(val[7:0]);
        btt_pkg::REG_DYING:  dying = int'(val[7:0]);
        btt_pkg::REG_ALIVE:  alive = int'(val[7:0]);
        default: ;  // unmapped index has no effect
      endcase
    endfunction

    function void add_expected(btt_pkg::res_t r);
      expected_q = {expected_q, r};
    endfunction

    function btt_pkg::res_t make_res(bit rk, logic [1:0] st, int s, bit lst);
      btt_pkg::res_t r;
      r = '0;
      r.report_kind = rk;
      r.status = st;
      r.last = lst;
      if (s >= 0) begin
        r.track_id = 16'(id[s]);
        r.pos_x = 14'(px[s]);
        r.pos_y = 13'(py[s]);
        r.prev_x = 14'(ox[s]);
        r.prev_y = 13'(oy[s]);
        r.life_state = 2'(life[s]);
        r.alpha = 8'(alpha[s]);
      end
      return r;
    endfunction

    // gated smoothing step on one axis, Q.4
    function int unsigned step_axis(int unsigned pos, int unsigned tgt, int unsigned g);
      int unsigned mag, stp;
      mag = (tgt >= pos) ? tgt - pos : pos - tgt;
      stp = (mag * g) >> 8;
      if (stp >= min_step * 16 && stp <= max_step * 16)
        return (tgt >= pos) ? pos + stp : pos - stp;
      return pos;
    endfunction

    function void note_request(logic kind, logic [9:0] det_x, logic [8:0] det_y,
                               logic [31:0] frame);
      int unsigned tx, ty, g, since;
      longint      r2, dx, dy;
      int          first, free_slot, a, n;
      logic [31:0] diff;
      n_req++;
      if (kind == btt_pkg::KIND_DET) begin
        tx = det_x * 16;
        ty = det_y * 16;
        g = (gain > 256) ? 256 : gain;
        r2 = longint'(radius) * 16 * longint'(radius) * 16;
        first = -1;
        free_slot = -1;
        for (int j = 0; j < DEPTH; j++) begin
          if (!live[j]) begin
            if (free_slot < 0) free_slot = j;
            continue;
          end
          dx = longint'(tx) - longint'(px[j]);
          dy = longint'(ty) - longint'(py[j]);
          if (dx * dx + dy * dy < r2) begin
            if (first < 0) first = j;
            ox[j] = px[j];
            oy[j] = py[j];
            px[j] = step_axis(px[j], tx, g);
            py[j] = step_axis(py[j], ty, g);
            stamp[j] = frame;
          end
        end
        if (first >= 0) begin
          n_match++;
          add_expected(make_res(1'b0, btt_pkg::ST_MATCHED, first, 1'b1));
        end else if (free_slot >= 0) begin
          live[free_slot] = 1;
          id[free_slot] = next_id;
          next_id = (next_id + 1) & 16'hffff;
          px[free_slot] = tx; py[free_slot] = ty;
          ox[free_slot] = tx; oy[free_slot] = ty;
          stamp[free_slot] = frame;
          age[free_slot] = 0;
          life[free_slot] = int'(btt_pkg::LIFE_UPCOMING);
          alpha[free_slot] = 0;
          n_new++;
          add_expected(make_res(1'b0, btt_pkg::ST_NEW, free_slot, 1'b1));
        end else begin
          n_drop++;
          add_expected(make_res(1'b0, btt_pkg::ST_DROPPED, -1, 1'b1));
        end
        return;
      end
      // end of batch: expire stale tracks first
      for (int j = 0; j < DEPTH; j++) begin
        diff = frame - stamp[j];
        if (live[j] && diff > expire) live[j] = 0;
      end
      // life, fade and age update
      for (int j = 0; j < DEPTH; j++) begin
        if (!live[j]) continue;
        diff = frame - stamp[j];
        since = diff;
        a = alpha[j];
        if (life[j] == btt_pkg::LIFE_UPCOMING) a = (int'(age[j]) - 10) * 5;
        if (age[j] > alive) begin
          life[j] = int'(btt_pkg::LIFE_ALIVE);
          a = 255;
        end
        if (since > dying) begin
          life[j] = int'(btt_pkg::LIFE_DYING);
          a -= 5 * int'(since & 8'hff);
        end
        if (life[j] != btt_pkg::LIFE_DYING && age[j] < 255) age[j]++;
        if (a > 255) a = 255;
        if (a < 0) a = 0;
        alpha[j] = a;
      end
      // one report per remaining track, last flag on the final one
      n = 0;
      for (int j = 0; j < DEPTH; j++) begin
        if (!live[j]) continue;
        add_expected(make_res(1'b1, btt_pkg::ST_MATCHED, j, 1'b0));
        n++;
      end
      if (n == 0) begin
        n_empty++;
        add_expected(make_res(1'b1, btt_pkg::ST_EMPTY, -1, 1'b1));
      end else begin
        n_tracks += n;
        expected_q[expected_q.size() - 1].last = 1'b1;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task cmp(string name, longint unsigned got, longint unsigned want, int idx);
      if (got != want)
        report($sformatf("result %0d field %s got %0d want %0d", idx, name, got, want));
    endtask

    task check_result(btt_pkg::res_t got);
      btt_pkg::res_t want;
      n_res++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", n_res));
        return;
      end
      want = expected_q.pop_front();
      cmp("report_kind", 64'(got.report_kind), 64'(want.report_kind), n_res);
      cmp("status", 64'(got.status), 64'(want.status), n_res);
      cmp("track_id", 64'(got.track_id), 64'(want.track_id), n_res);
      cmp("pos_x", 64'(got.pos_x), 64'(want.pos_x), n_res);
      cmp("pos_y", 64'(got.pos_y), 64'(want.pos_y), n_res);
      cmp("prev_x", 64'(got.prev_x), 64'(want.prev_x), n_res);
      cmp("prev_y", 64'(got.prev_y), 64'(want.prev_y), n_res);
      cmp("life_state", 64'(got.life_state), 64'(want.life_state), n_res);
      cmp("alpha", 64'(got.alpha), 64'(want.alpha), n_res);
      cmp("last", 64'(got.last), 64'(want.last), n_res);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [8:0]  cfg_data;

  track_scoreboard sb;
  bit          calm;       // set for the last part: no idling at all
  bit          hold_req;   // sender asks the receiver for a long hold-off
  int          quiet_cycles;

  blob_track_table_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // result monitor: every accepted result is checked against the oldest one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    btt_pkg::res_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.report_kind = m_axis_tuser;
      got.status = m_axis_tdata[1:0];
      got.track_id = m_axis_tdata[17:2];
      got.pos_x = m_axis_tdata[31:18];
      got.pos_y = m_axis_tdata[44:32];
      got.prev_x = m_axis_tdata[58:45];
      got.prev_y = m_axis_tdata[71:59];
      got.life_state = m_axis_tdata[73:72];
      got.alpha = m_axis_tdata[81:74];
      got.last = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------
  task write_reg(logic [2:0] idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task write_all(int r, int g, int mn, int mx, int ex, int dy, int al);
    write_reg(btt_pkg::REG_RADIUS, 9'(r));
    write_reg(btt_pkg::REG_GAIN, 9'(g));
    write_reg(btt_pkg::REG_MINSTP, 9'(mn));
    write_reg(btt_pkg::REG_MAXSTP, 9'(mx));
    write_reg(btt_pkg::REG_EXPIRE, 9'(ex));
    write_reg(btt_pkg::REG_DYING, 9'(dy));
    write_reg(btt_pkg::REG_ALIVE, 9'(al));
  endtask

  // one request; valid stays high into the next one unless a gap is drawn
  task send_request(logic kind, logic [9:0] x, logic [8:0] y, logic [31:0] frame);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {5'b0, frame, y, x};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(kind, x, y, frame);
  endtask

  // sender pause: every expected result in, then let the block settle
  task drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // random batches around a handful of blob centers
  task random_phase(int count);
    int          cx [6], cy [6];
    int          k, x, y;
    logic [31:0] frame;
    foreach (cx[i]) begin
      cx[i] = $urandom_range(0, 1023);
      cy[i] = $urandom_range(0, 511);
    end
    frame = $urandom;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 11);
      if (k < 2) begin
        // end of batch, frame moves on; sometimes a big jump to expire tracks
        frame = frame + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 300)
                                                    : $urandom_range(0, 3));
        send_request(btt_pkg::KIND_EOB, 10'($urandom), 9'($urandom), frame);
      end else if (k < 10) begin
        // detection near a known blob, with jitter
        x = cx[$urandom_range(0, 5) % 6];
        y = cy[$urandom_range(0, 5) % 6];
        x = x + $urandom_range(0, 80) - 40;
        y = y + $urandom_range(0, 80) - 40;
        x = (x < 0) ? 0 : (x > 1023) ? 1023 : x;
        y = (y < 0) ? 0 : (y > 511) ? 511 : y;
        send_request(btt_pkg::KIND_DET, 10'(x), 9'(y), frame);
      end else begin
        // stray detection anywhere, odd frame stamp now and then
        send_request(btt_pkg::KIND_DET, 10'($urandom), 9'($urandom),
                     ($urandom_range(0, 3) == 0) ? $urandom : frame);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    @(negedge rst);
    @(posedge clk);

    // directed part with reset defaults: empty table, extremes, small and
    // large steps, table full, dying sweep, full expiry
    send_request(btt_pkg::KIND_EOB, 10'h3ff, 9'h1ff, 32'd0);
    send_request(btt_pkg::KIND_DET, 10'd0, 9'd0, 32'd0);
    send_request(btt_pkg::KIND_DET, 10'd1023, 9'd511, 32'd0);
    send_request(btt_pkg::KIND_DET, 10'd10, 9'd0, 32'd0);
    send_request(btt_pkg::KIND_DET, 10'd1, 9'd1, 32'd0);
    for (int i = 0; i < 15; i++)
      send_request(btt_pkg::KIND_DET, 10'd100 + 10'(60 * i), 9'd200, 32'd1);
    send_request(btt_pkg::KIND_EOB, 10'd0, 9'd0, 32'd3);
    send_request(btt_pkg::KIND_EOB, 10'd0, 9'd0, 32'd50);
    send_request(btt_pkg::KIND_DET, 10'd512, 9'd256, 32'hffff_fffe);
    send_request(btt_pkg::KIND_EOB, 10'd0, 9'd0, 32'd1);
    drain();

    // wide-open settings, gain above unity, unmapped index; long receiver
    // hold-off while the sender keeps offering requests
    write_all(255, 511, 0, 255, 255, 255, 0);
    write_reg(REG_UNMAPPED, 9'h1ff);
    hold_req = 1'b1;
    random_phase(30);
    drain();

    // tightest settings: nothing moves, everything dies and expires at once
    write_all(1, 0, 255, 0, 0, 0, 255);
    random_phase(25);
    drain();

    for (int p = 0; p < 3; p++) begin
      write_all($urandom_range(1, 255), $urandom_range(0, 511), $urandom_range(0, 8),
                $urandom_range(8, 255), $urandom_range(0, 255), $urandom_range(0, 10),
                $urandom_range(0, 10));
      if (p == 2) calm = 1'b1;
      random_phase(p == 2 ? 30 : 25);
      drain();
    end

    $display("ran %0d requests, checked %0d results", sb.n_req, sb.n_res);
    $display("opened %0d tracks, matched %0d, dropped %0d, %0d track reports, %0d empty",
             sb.n_new, sb.n_match, sb.n_drop, sb.n_tracks, sb.n_empty);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
